### sv/mpw_pkg.sv
package mpw_pkg;

    // Default index width of the walker (node count is taken modulo 2^this)
    localparam int IDX_BITS_DEF = 16;

    // Fixed field widths of the stream payloads
    localparam int IN_LEN_W   = 16;
    localparam int OUT_IDX_W  = 16;
    localparam int OUT_H_W    = 4;
    localparam int PEAK_CNT_W = 5;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 64;
    localparam int TUSER_W    = 3;

    // Results kept per input beat; the rest are dropped
    localparam int MAX_RESULTS = 46;
    localparam int RES_CNT_W   = 6;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_EMPTY    = 2'd1;
    localparam status_t STATUS_NO_PEAKS = 2'd2;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_SINGLE,
        KIND_WALK
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAKS,
        ST_SLOPE_L,
        ST_SLOPE_R,
        ST_FINISH
    } walk_state_t;

endpackage

### sv/mpw_front.sv
module mpw_front
    import mpw_pkg::*;
#(
    parameter int INDEX_BITS = IDX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_LEN_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output logic [((INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W)
                  + $clog2((INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W)
                  + 2:0]        cmd_data
);

    localparam int LW = (INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W;
    localparam int PW = LW + 1;
    localparam int HW = $clog2(LW);
    localparam int CW = 2 + LW + 1 + HW;

    logic          fv_reg, fv_next;
    logic [CW-1:0] cmd_reg, cmd_next;

    logic [LW-1:0] len;
    logic [PW-1:0] len_p1;
    logic [HW-1:0] h0;
    cmd_kind_t     kind;
    logic          take;

    assign len      = s_tdata[LW-1:0];
    assign len_p1   = PW'(len) + PW'(1);
    assign s_tready = !fv_reg || cmd_ready;
    assign take     = s_tvalid && s_tready;

    // Starting height: floor(log2(len + 1)) - 1
    always_comb begin
        h0 = '0;
        for (int i = 1; i < PW; i++) begin
            if (len_p1[i]) h0 = HW'(i - 1);
        end
    end

    always_comb begin
        priority if (len == '0) begin
            kind = KIND_EMPTY;
        end else if (len == LW'(1)) begin
            kind = KIND_SINGLE;
        end else begin
            kind = KIND_WALK;
        end
    end

    always_comb begin
        fv_next  = fv_reg && !cmd_ready;
        cmd_next = cmd_reg;
        if (take) begin
            fv_next  = 1'b1;
            cmd_next = {h0, s_tuser, len, kind};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = fv_reg;
    assign cmd_data  = cmd_reg;

endmodule

### sv/mpw_queue.sv
module mpw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    // two-entry command queue
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) entry_reg[wr_ptr_reg] <= in_data;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("queue fill count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

    a_one_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd1 |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with single entry");

endmodule

### sv/mpw_back.sv
module mpw_back
    import mpw_pkg::*;
#(
    parameter int INDEX_BITS = IDX_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [((INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W)
                  + $clog2((INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W)
                  + 2:0]       cmd_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,
    output logic               m_tlast
);

    localparam int LW    = (INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W;
    localparam int PW    = LW + 1;
    localparam int HW    = $clog2(LW);
    localparam int EW    = (PW > OUT_IDX_W) ? PW : OUT_IDX_W;
    localparam int PAD_W = TDATA_W - 3 * OUT_IDX_W - OUT_H_W - PEAK_CNT_W;

    // command fields
    cmd_kind_t     c_kind;
    logic [LW-1:0] c_len;
    logic          c_extra;
    logic [HW-1:0] c_h0;

    assign c_kind  = cmd_kind_t'(cmd_data[1:0]);
    assign c_len   = cmd_data[LW+1:2];
    assign c_extra = cmd_data[LW+2];
    assign c_h0    = cmd_data[LW+HW+2:LW+3];

    walk_state_t             state_reg, state_next;
    logic [LW-1:0]           len_reg, len_next;
    logic                    extra_reg, extra_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [HW-1:0]           h_reg, h_next;
    logic [PW-1:0]           lpos_reg, lpos_next;
    logic [HW-1:0]           lh_reg, lh_next;
    logic [PEAK_CNT_W-1:0]   peaks_reg, peaks_next;
    logic [RES_CNT_W-1:0]    cnt_reg, cnt_next;

    // held result: its last flag is known only once the next one shows up
    logic                    pend_valid_reg, pend_valid_next;
    logic [PW-1:0]           pend_pos_reg, pend_pos_next;
    logic [HW-1:0]           pend_h_reg, pend_h_next;
    logic                    pend_x_reg, pend_x_next;

    logic                    out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]      out_tdata_reg, out_tdata_next;
    logic [TUSER_W-1:0]      out_tuser_reg, out_tuser_next;
    logic                    out_tlast_reg, out_tlast_next;

    // formatted view of the held result
    logic [EW-1:0]        pp, ph_pow;
    logic [OUT_IDX_W-1:0] f_idx, f_lc, f_rc;

    assign pp     = EW'(pend_pos_reg);
    assign ph_pow = EW'(1) << pend_h_reg;
    assign f_idx  = OUT_IDX_W'(pp - EW'(1));
    assign f_lc   = (pend_h_reg != '0) ? OUT_IDX_W'(pp - ph_pow - EW'(1)) : '0;
    assign f_rc   = (pend_h_reg != '0) ? OUT_IDX_W'(pp - EW'(2)) : '0;

    // peak step
    logic          desc;
    logic [PW-1:0] pos1;
    logic [HW-1:0] h1;
    logic          take_pk;

    assign desc    = pos_reg > PW'(len_reg);
    assign pos1    = desc ? (pos_reg - (PW'(1) << h_reg)) : pos_reg;
    assign h1      = desc ? (h_reg - HW'(1)) : h_reg;
    assign take_pk = pos1 <= PW'(len_reg);

    logic          out_free;
    logic          gen_valid;
    logic [PW-1:0] gen_pos;
    logic [HW-1:0] gen_h;
    logic          gen_x;
    logic          push_pend, fin_load, stat_load;
    status_t       stat_code;

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        extra_next      = extra_reg;
        pos_next        = pos_reg;
        h_next          = h_reg;
        lpos_next       = lpos_reg;
        lh_next         = lh_reg;
        peaks_next      = peaks_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_h_next     = pend_h_reg;
        pend_x_next     = pend_x_reg;
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;
        out_tdata_next  = out_tdata_reg;
        out_tuser_next  = out_tuser_reg;
        out_tlast_next  = out_tlast_reg;
        gen_valid       = 1'b0;
        gen_pos         = '0;
        gen_h           = '0;
        gen_x           = 1'b0;
        push_pend       = 1'b0;
        fin_load        = 1'b0;
        stat_load       = 1'b0;
        stat_code       = STATUS_OK;
        cmd_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = out_free;
                if (cmd_valid && out_free) begin
                    unique case (c_kind)
                        KIND_EMPTY: begin
                            stat_load = 1'b1;
                            stat_code = STATUS_EMPTY;
                        end
                        KIND_SINGLE: begin
                            pend_valid_next = 1'b1;
                            pend_pos_next   = PW'(1);
                            pend_h_next     = '0;
                            pend_x_next     = 1'b0;
                            peaks_next      = PEAK_CNT_W'(1);
                            state_next      = ST_FINISH;
                        end
                        KIND_WALK: begin
                            len_next        = c_len;
                            extra_next      = c_extra;
                            h_next          = c_h0;
                            pos_next        = (PW'(2) << c_h0) - PW'(1);
                            lpos_next       = '0;
                            lh_next         = '0;
                            peaks_next      = '0;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_PEAKS;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PEAKS: begin
                if (out_free) begin
                    if (h_reg == '0) begin
                        priority if (!pend_valid_reg) begin
                            stat_load  = 1'b1;
                            stat_code  = STATUS_NO_PEAKS;
                            state_next = ST_IDLE;
                        end else if (extra_reg && lh_reg != '0) begin
                            pos_next   = lpos_reg;
                            h_next     = lh_reg;
                            state_next = ST_SLOPE_L;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        h_next   = h1;
                        pos_next = pos1;
                        if (take_pk) begin
                            gen_valid  = 1'b1;
                            gen_pos    = pos1;
                            gen_h      = h1;
                            lpos_next  = pos1;
                            lh_next    = h1;
                            peaks_next = peaks_reg + PEAK_CNT_W'(1);
                            pos_next   = pos1 + (PW'(2) << h1) - PW'(1);
                        end
                    end
                end
            end
            ST_SLOPE_L: begin
                if (out_free) begin
                    gen_valid  = 1'b1;
                    gen_pos    = pos_reg - (PW'(1) << h_reg);
                    gen_h      = h_reg - HW'(1);
                    gen_x      = 1'b1;
                    state_next = ST_SLOPE_R;
                end
            end
            ST_SLOPE_R: begin
                if (out_free) begin
                    gen_valid  = 1'b1;
                    gen_pos    = pos_reg - PW'(1);
                    gen_h      = h_reg - HW'(1);
                    gen_x      = 1'b1;
                    pos_next   = pos_reg - PW'(1);
                    h_next     = h_reg - HW'(1);
                    state_next = (h_reg == HW'(1)) ? ST_FINISH : ST_SLOPE_L;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    fin_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // new result below the cap: the held one moves out, the new one is held
        if (gen_valid && cnt_reg < RES_CNT_W'(MAX_RESULTS)) begin
            push_pend       = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_pos_next   = gen_pos;
            pend_h_next     = gen_h;
            pend_x_next     = gen_x;
            cnt_next        = cnt_reg + RES_CNT_W'(1);
        end

        if (push_pend || fin_load) begin
            out_valid_next = 1'b1;
            out_tdata_next = {{PAD_W{1'b0}},
                              fin_load ? peaks_reg : PEAK_CNT_W'(0),
                              f_rc, f_lc, OUT_H_W'(pend_h_reg), f_idx};
            out_tuser_next = {STATUS_OK, pend_x_reg};
            out_tlast_next = fin_load;
        end else if (stat_load) begin
            out_valid_next = 1'b1;
            out_tdata_next = '0;
            out_tuser_next = {stat_code, 1'b0};
            out_tlast_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            peaks_reg      <= '0;
            pos_reg        <= '0;
            h_reg          <= '0;
            lpos_reg       <= '0;
            lh_reg         <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            peaks_reg      <= peaks_next;
            pos_reg        <= pos_next;
            h_reg          <= h_next;
            lpos_reg       <= lpos_next;
            lh_reg         <= lh_next;
        end
        len_reg       <= len_next;
        extra_reg     <= extra_next;
        pend_pos_reg  <= pend_pos_next;
        pend_h_reg    <= pend_h_next;
        pend_x_reg    <= pend_x_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
        out_tlast_reg <= out_tlast_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;
    assign m_tlast  = out_tlast_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count beyond cap");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held result left over in idle");

    a_slope_height: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOPE_L || state_reg == ST_SLOPE_R) |-> h_reg != '0)
        else $error("slope walk at leaf height");

    a_finish_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> pend_valid_reg)
        else $error("finish without a held result");

endmodule

### sv/mmr_peak_index_walker_unit.sv
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   tdata: tree_length; tuser: want_extra
// m_        out  m_tvalid/tready   tdata: index, height, children, peak_total;
//                                  tuser: is_extra, status; tlast: last
//
// Front stage registers and classifies each input beat, a two-entry queue
// buffers commands, the back walker emits at most one result beat per cycle.
// A walked item runs the peak loop (one descend/take step per cycle while
// the output is free), then a left and a right slope step per level when
// asked, then a finish step. An empty tree gives only a status beat, a single
// leaf goes straight to the finish step, a length without peaks ends in a status beat.
// Reset (aresetn low, synchronous) empties the queue and output register.
// Output stalls freeze the walker; front and queue take input beats until full.
module mmr_peak_index_walker_unit
    import mpw_pkg::*;
#(
    parameter int INDEX_BITS = IDX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_LEN_W-1:0] s_tdata,   // [15:0] tree_length
    input  logic                s_tuser,   // [0] want_extra
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [15:0] node_index, [19:16] node_height,
                                           // [35:20] left_child_index,
                                           // [51:36] right_child_index,
                                           // [56:52] peak_total, rest zero
    output logic [TUSER_W-1:0]  m_tuser,   // [0] is_extra, [2:1] status
    output logic                m_tlast
);

    localparam int LW = (INDEX_BITS < IN_LEN_W) ? INDEX_BITS : IN_LEN_W;
    localparam int HW = $clog2(LW);
    localparam int CW = 2 + LW + 1 + HW;

    logic          f_valid, f_ready;
    logic [CW-1:0] f_data;
    logic          q_valid, q_ready;
    logic [CW-1:0] q_data;

    // input beat -> classified command
    mpw_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    mpw_queue #(
        .WIDTH(CW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // peak walk, right-slope walk, result formatting
    mpw_back #(
        .INDEX_BITS(INDEX_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### tb/tb.sv
module tb;
    import mpw_pkg::*;

    // Bench timing
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 275;
    // Drain after the last expected beat, scaled with the index width, so
    // that stray beats still show up.
    localparam int TAIL_CYCLES  = 4 * IDX_BITS_DEF + 16;
    // Watchdog limit in time units, sized for the worst case of every item with all its result beats stalled.
    localparam int WATCHDOG     = 20_000_000;
    localparam int MAX_REPORTS  = 40;

    // Lengths of the directed part: empty, single leaf, no peaks, well-formed
    // and malformed ranges, and the ends of the 16-bit field.
    localparam int N_EDGE = 21;
    localparam logic [IN_LEN_W-1:0] EDGE_LENS [N_EDGE] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
        16'd9, 16'd10, 16'd11, 16'd15, 16'd19, 16'd25, 16'h7FFF, 16'h8000,
        16'hAAAA, 16'h5555, 16'hFFFE, 16'hFFFF
    };

    // One result beat, field by field
    typedef struct packed {
        logic [OUT_IDX_W-1:0]  node_idx;
        logic [OUT_H_W-1:0]    height;
        logic [OUT_IDX_W-1:0]  left_idx;
        logic [OUT_IDX_W-1:0]  right_idx;
        logic                  slope;
        logic [PEAK_CNT_W-1:0] peak_total;
        status_t               status;
        logic                  last;
    } peak_entry_t;

    // One input beat waiting to be sent, with its lead-in gap
    typedef struct {
        logic [IN_LEN_W-1:0] len;
        logic                want;
        int unsigned         gap;
    } length_req_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_LEN_W-1:0] s_tdata  = '0;   // [15:0] tree_length
    logic                s_tuser  = 1'b0; // [0] want_extra
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;         // [15:0] node_index, [19:16] node_height,
                                          // [35:20] left_child_index,
                                          // [51:36] right_child_index,
                                          // [56:52] peak_total, rest zero
    logic [TUSER_W-1:0]  m_tuser;         // [0] is_extra, [2:1] status
    logic                m_tlast;

    length_req_t pending_lengths[$];  // stimulus not yet offered
    peak_entry_t expected_beats[$];   // predicted beats not yet seen

    length_req_t pend;
    bit          have_pend = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned rx_wait   = 0;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;
    bit          in_beat   = 1'b0;
    bit          out_beat  = 1'b0;

    int unsigned errors    = 0;
    int unsigned n_in      = 0;
    int unsigned n_out     = 0;
    int unsigned n_slope   = 0;
    int unsigned n_status  = 0;

    mmr_peak_index_walker_unit #(
        .INDEX_BITS(IDX_BITS_DEF)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Node beat for MMR position pos (one-based) at height hgt.
    // Children of a node at p sit at p - 2^h - 1 and p - 2 (array indices).
    function automatic peak_entry_t mk_node(int unsigned pos, int unsigned hgt, logic slope);
        peak_entry_t e;
        e = '0;
        e.node_idx = OUT_IDX_W'(pos - 1);
        e.height   = OUT_H_W'(hgt);
        if (hgt != 0) begin
            e.left_idx  = OUT_IDX_W'(pos - (32'd1 << hgt) - 1);
            e.right_idx = OUT_IDX_W'(pos - 2);
        end
        e.slope = slope;
        return e;
    endfunction

    function automatic peak_entry_t mk_status(status_t code);
        peak_entry_t e;
        e = '0;
        e.status = code;
        e.last   = 1'b1;
        return e;
    endfunction

    // Predicts every beat that one input length causes and queues them.
    function automatic void walk_peaks(logic [IN_LEN_W-1:0] len_in, logic want);
        peak_entry_t res[$];
        int unsigned len, hgt, pos, t, lg, peaks, top_pos, top_h, lpos, rpos;
        len     = 32'(len_in);
        peaks   = 0;
        top_pos = 0;
        top_h   = 0;
        if (len == 0) begin
            expected_beats = {expected_beats, mk_status(STATUS_EMPTY)};
            return;
        end
        // single leaf: flag is ignored
        if (len == 1) begin
            res = {res, mk_node(1, 0, 1'b0)};
            res[0].peak_total = PEAK_CNT_W'(1);
            res[0].last       = 1'b1;
            expected_beats = {expected_beats, res[0]};
            return;
        end
        // start at the tallest perfect tree that fits: h = floor(log2(len+1)) - 1
        lg = 0;
        t  = len + 1;
        while (t > 1) begin
            t >>= 1;
            lg++;
        end
        hgt = lg - 1;
        pos = (32'd1 << (hgt + 1)) - 1;
        // descend while the candidate lies past the end, take it otherwise;
        // malformed lengths follow the same rule
        while (hgt != 0) begin
            if (pos > len) begin
                pos -= (32'd1 << hgt);
                hgt--;
            end
            if (pos <= len) begin
                if (res.size() < MAX_RESULTS) res = {res, mk_node(pos, hgt, 1'b0)};
                top_pos = pos;
                top_h   = hgt;
                peaks++;
                pos += (32'd1 << (hgt + 1)) - 1;
            end
        end
        if (res.size() == 0) begin
            expected_beats = {expected_beats, mk_status(STATUS_NO_PEAKS)};
            return;
        end
        // right slope of the last peak: left child, then right child, per level
        if (want) begin
            hgt = top_h;
            pos = top_pos;
            while (hgt > 0) begin
                lpos = pos - (32'd1 << hgt);
                rpos = pos - 1;
                hgt--;
                if (res.size() < MAX_RESULTS) res = {res, mk_node(lpos, hgt, 1'b1)};
                if (res.size() < MAX_RESULTS) res = {res, mk_node(rpos, hgt, 1'b1)};
                pos = rpos;
            end
        end
        // overflowed beats are gone; the last kept one closes the run
        res[res.size()-1].peak_total = PEAK_CNT_W'(peaks);
        res[res.size()-1].last       = 1'b1;
        expected_beats = {expected_beats, res};
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Queue one length; the sender alternates between idle-heavy and
    // back-to-back stretches.
    function automatic void add_item(logic [IN_LEN_W-1:0] len, logic want);
        length_req_t it;
        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        it.len  = len;
        it.want = want;
        it.gap  = tx_calm ? 0 : $urandom_range(0, 15);
        pending_lengths = {pending_lengths, it};
    endfunction

    // Input side: every accepted beat is handed to the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            walk_peaks(s_tdata, s_tuser);
            n_in++;
        end
        in_beat <= aresetn && s_tvalid && s_tready;
    end

    // Input driver, on the falling edge. tvalid holds until the beat is
    // taken; the next item follows after its own gap, or at once when the
    // gap is zero, so tvalid gets exactly one assignment per edge.
    always @(negedge aclk) begin : drv_in
        logic nv;
        nv = s_tvalid;
        if (aresetn && (!s_tvalid || in_beat)) begin
            if (!have_pend && pending_lengths.size() != 0) begin
                pend      = pending_lengths.pop_front();
                have_pend = 1'b1;
                gap_left  = pend.gap;
            end
            nv = 1'b0;
            if (have_pend) begin
                if (gap_left == 0) begin
                    nv        = 1'b1;
                    s_tdata  <= pend.len;
                    s_tuser  <= pend.want;
                    have_pend = 1'b0;
                end else begin
                    gap_left--;
                end
            end
        end
        s_tvalid <= nv;
    end

    // Result side: each beat is checked against the oldest prediction.
    always @(posedge aclk) begin : mon_out
        peak_entry_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_out++;
            if (expected_beats.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, got index %0d status %0d",
                             $time, m_tdata[15:0], m_tuser[2:1]);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (e.slope) n_slope++;
                if (e.status != STATUS_OK) n_status++;
                check_field("node_index",        64'(e.node_idx),   64'(m_tdata[15:0]));
                check_field("node_height",       64'(e.height),     64'(m_tdata[19:16]));
                check_field("left_child_index",  64'(e.left_idx),   64'(m_tdata[35:20]));
                check_field("right_child_index", 64'(e.right_idx),  64'(m_tdata[51:36]));
                check_field("peak_total",        64'(e.peak_total), 64'(m_tdata[56:52]));
                check_field("tdata padding",     64'(0),      64'(m_tdata[TDATA_W-1:57]));
                check_field("is_extra",          64'(e.slope),      64'(m_tuser[0]));
                check_field("status",            64'(e.status),     64'(m_tuser[2:1]));
                check_field("last",              64'(e.last),       64'(m_tlast));
            end
        end
        out_beat <= aresetn && m_tvalid && m_tready;
    end

    // Backpressure: after every taken beat draw a random stall length,
    // with stretches of no stall at all.
    always @(negedge aclk) begin : drv_out
        int unsigned w;
        w = rx_wait;
        if (out_beat) begin
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 15);
        end
        if (w != 0) begin
            m_tready <= 1'b0;
            rx_wait   = w - 1;
        end else begin
            m_tready <= 1'b1;
            rx_wait   = 0;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned i, leaves, len;
        // directed: edge lengths with the flag alternating, then the single leaf,
        // the full range and lengths 65534 and 7 with the other flag value
        for (i = 0; i < N_EDGE; i++) add_item(EDGE_LENS[i], i[0]);
        add_item(16'd1, 1'b0);
        add_item(16'hFFFF, 1'b1);
        add_item(16'hFFFE, 1'b0);
        add_item(16'd7, 1'b0);
        // random: well-formed ranges (2n - popcount(n) nodes for n leaves),
        // short lengths, and arbitrary 16-bit values
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    leaves = $urandom_range(1, 32768);
                    len    = 2 * leaves - $countones(leaves);
                end
                4, 5, 6: begin
                    len = $urandom_range(0, 40);
                end
                default: begin
                    len = $urandom_range(0, 65535);
                end
            endcase
            add_item(IN_LEN_W'(len), 1'($urandom_range(0, 1)));
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_lengths.size() != 0 || have_pend || s_tvalid) @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_beats.size() != 0) begin
            $display("%0t: %0d predicted beats never arrived", $time, expected_beats.size());
            errors++;
        end
        $display("Walked %0d lengths, compared %0d result beats", n_in, n_out);
        $display("  of them %0d right-slope entries and %0d status beats, %0d errors",
                 n_slope, n_status, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #(WATCHDOG);
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
